[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Every check is sampled on aclk and held off while aresetn is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante holds.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

[src/sexpr_pkg.sv]
// ----------------------------------------------------------------------------
// sexpr_pkg
// Types, codes and sizing constants for the S-expression framer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sexpr_pkg;

    // Sizing
    localparam int MAX_CHARS  = 4096;
    localparam int DEPTH_BITS = 8;
    localparam int COL_W      = $clog2(MAX_CHARS) + 1;
    localparam int CNT_W      = $clog2(MAX_CHARS) + 1;

    localparam logic [COL_W-1:0]      COL_LIMIT = COL_W'(MAX_CHARS - 2);
    localparam logic [CNT_W-1:0]      CNT_LIMIT = CNT_W'(MAX_CHARS - 1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = {DEPTH_BITS{1'b1}};

    // Result queue; depth must be a power of two so the pointers wrap freely
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Bytes of interest
    localparam logic [7:0] CH_NL     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_SPACE  = 8'd32;
    localparam logic [7:0] CH_QUOTE  = 8'd34;
    localparam logic [7:0] CH_HASH   = 8'd35;
    localparam logic [7:0] CH_LPAREN = 8'd40;
    localparam logic [7:0] CH_RPAREN = 8'd41;
    localparam logic [7:0] CH_SEMI   = 8'd59;
    localparam logic [7:0] CH_BSLASH = 8'd92;

    typedef enum logic [1:0] {
        ST_OK  = 2'd0,
        ST_ERR = 2'd1,
        ST_END = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ERR_NONE         = 4'd0,
        ERR_MISSING_RPAR = 4'd1,
        ERR_LEADING_RPAR = 4'd2,
        ERR_TRAILING     = 4'd3,
        ERR_EXTRA_RPAR   = 4'd4,
        ERR_STR_AFTER    = 4'd5,
        ERR_OPEN_STRING  = 4'd6,
        ERR_LONG_LINE    = 4'd7,
        ERR_LONG_EXPR    = 4'd8,
        ERR_TOO_DEEP     = 4'd9
    } err_t;

    typedef enum logic [2:0] {
        K_NONE   = 3'd0,
        K_STRING = 3'd1,
        K_ATOM   = 3'd2,
        K_PAREN  = 3'd3,
        K_DONE   = 3'd4
    } kind_t;

    typedef struct packed {
        status_t status;
        err_t    error_kind;
        logic    last;
    } res_t;

endpackage

[src/sexpr_framer_unit.sv]
// ----------------------------------------------------------------------------
// sexpr_framer_unit
// Byte-stream S-expression framer with a small result queue.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_valid/s_ready): one text byte per transfer, or an
//   end-of-input marker when s_end_of_input is high (s_char_in is ignored).
//   Result channel (m_valid/m_ready): status, error kind and a last flag that
//   marks the final result caused by one input transfer.
//   Each input transfer updates the parse state as it is accepted and
//   pushes zero, one or two results into a four-entry queue. Results are
//   offered on the m_ side from the queue registers, oldest first.
//   Throughput: one input byte per cycle while s_ready is high; a result
//   leaves at most once per cycle.
//   s_ready is high while the queue has room for two results, so a stalled
//   receiver holds results in the queue and back-pressures the input once
//   three entries pile up; nothing is dropped.
//   Reset (aresetn low, synchronous) clears the parse state and empties the
//   queue. End of input also returns the parse state to its reset value.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sexpr_framer_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_end_of_input,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [1:0] m_status,
    output logic [3:0] m_error_kind,
    output logic       m_last_result
);

    // Parse state
    logic [sexpr_pkg::DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                             instr_reg, instr_next;
    sexpr_pkg::kind_t                 kind_reg, kind_next;
    logic [7:0]                       prev_reg, prev_next;
    logic [7:0]                       prev2_reg, prev2_next;
    logic [sexpr_pkg::COL_W-1:0]      column_reg, column_next;
    logic [sexpr_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                             useful_reg, useful_next;
    logic                             comment_reg, comment_next;
    logic                             skip_reg, skip_next;

    // Result queue
    sexpr_pkg::res_t                  q_reg [sexpr_pkg::QDEPTH];
    logic [sexpr_pkg::QPTR_W-1:0]     head_reg, head_next;
    logic [sexpr_pkg::QPTR_W-1:0]     tail_reg, tail_next;
    logic [sexpr_pkg::QCNT_W-1:0]     qcnt_reg, qcnt_next;

    // Per-transfer results
    logic                             in_xfer;
    logic                             out_xfer;
    logic [1:0]                       n_res;
    sexpr_pkg::res_t                  res0, res1;
    logic                             space, lit, fail_hit, go;
    sexpr_pkg::err_t                  fail_code;
    logic [sexpr_pkg::CNT_W-1:0]      cnt_tmp;

    assign s_ready  = (qcnt_reg <= sexpr_pkg::QCNT_W'(sexpr_pkg::QDEPTH - 2));
    assign in_xfer  = s_valid && s_ready;
    assign m_valid  = (qcnt_reg != '0);
    assign out_xfer = m_valid && m_ready;

    assign m_status      = q_reg[head_reg].status;
    assign m_error_kind  = q_reg[head_reg].error_kind;
    assign m_last_result = q_reg[head_reg].last;

    assign space = (s_char_in == sexpr_pkg::CH_SPACE) ||
                   ((s_char_in >= sexpr_pkg::CH_TAB) && (s_char_in <= sexpr_pkg::CH_CR));
    // Character literal #\( or #\) does not count as a parenthesis
    assign lit   = (prev_reg == sexpr_pkg::CH_BSLASH) && (prev2_reg == sexpr_pkg::CH_HASH);

    // ------------------------------------------------------------------------
    // State update for one byte
    // ------------------------------------------------------------------------
    always_comb begin
        depth_next   = depth_reg;
        instr_next   = instr_reg;
        kind_next    = kind_reg;
        prev_next    = prev_reg;
        prev2_next   = prev2_reg;
        column_next  = column_reg;
        cnt_next     = cnt_reg;
        useful_next  = useful_reg;
        comment_next = comment_reg;
        skip_next    = skip_reg;
        n_res        = 2'd0;
        res0         = '{sexpr_pkg::ST_OK, sexpr_pkg::ERR_NONE, 1'b0};
        res1         = '{sexpr_pkg::ST_END, sexpr_pkg::ERR_NONE, 1'b1};
        fail_hit     = 1'b0;
        fail_code    = sexpr_pkg::ERR_NONE;
        go           = 1'b0;
        cnt_tmp      = cnt_reg;

        if (in_xfer) begin
            if (s_end_of_input) begin
                // Flush the pending expression, then report END
                if (!skip_reg) begin
                    if (instr_reg) begin
                        res0  = '{sexpr_pkg::ST_ERR, sexpr_pkg::ERR_OPEN_STRING, 1'b0};
                        n_res = 2'd1;
                    end else if (depth_reg != '0) begin
                        res0  = '{sexpr_pkg::ST_ERR, sexpr_pkg::ERR_MISSING_RPAR, 1'b0};
                        n_res = 2'd1;
                    end else if (useful_reg) begin
                        res0  = '{sexpr_pkg::ST_OK, sexpr_pkg::ERR_NONE, 1'b0};
                        n_res = 2'd1;
                    end
                end
                if (n_res == 2'd0) begin
                    res0  = '{sexpr_pkg::ST_END, sexpr_pkg::ERR_NONE, 1'b1};
                    n_res = 2'd1;
                end else begin
                    n_res = 2'd2;
                end
                depth_next   = '0;
                instr_next   = 1'b0;
                kind_next    = sexpr_pkg::K_NONE;
                cnt_next     = '0;
                column_next  = '0;
                prev_next    = '0;
                prev2_next   = '0;
                useful_next  = 1'b0;
                comment_next = 1'b0;
                skip_next    = 1'b0;
            end else if (s_char_in == sexpr_pkg::CH_NL) begin
                if (!skip_reg && useful_reg) begin
                    if (instr_reg) begin
                        depth_next = '0;
                        instr_next = 1'b0;
                        kind_next  = sexpr_pkg::K_NONE;
                        cnt_next   = '0;
                        res0  = '{sexpr_pkg::ST_ERR, sexpr_pkg::ERR_OPEN_STRING, 1'b1};
                        n_res = 2'd1;
                    end else if (depth_reg == '0) begin
                        depth_next = '0;
                        instr_next = 1'b0;
                        kind_next  = sexpr_pkg::K_NONE;
                        cnt_next   = '0;
                        res0  = '{sexpr_pkg::ST_OK, sexpr_pkg::ERR_NONE, 1'b1};
                        n_res = 2'd1;
                    end else begin
                        // Line break inside an open expression counts one byte
                        cnt_tmp  = cnt_reg + 1'b1;
                        cnt_next = cnt_tmp;
                        if (cnt_tmp > sexpr_pkg::CNT_LIMIT) begin
                            depth_next = '0;
                            instr_next = 1'b0;
                            kind_next  = sexpr_pkg::K_NONE;
                            cnt_next   = '0;
                            res0  = '{sexpr_pkg::ST_ERR, sexpr_pkg::ERR_LONG_EXPR, 1'b1};
                            n_res = 2'd1;
                        end
                    end
                end
                column_next  = '0;
                prev_next    = '0;
                prev2_next   = '0;
                useful_next  = 1'b0;
                comment_next = 1'b0;
                skip_next    = 1'b0;
            end else if (!skip_reg) begin
                if (column_reg >= sexpr_pkg::COL_LIMIT) begin
                    fail_hit  = 1'b1;
                    fail_code = sexpr_pkg::ERR_LONG_LINE;
                end else begin
                    column_next = column_reg + 1'b1;
                    if (!comment_reg) begin
                        if (!instr_reg && (s_char_in == sexpr_pkg::CH_SEMI)) begin
                            comment_next = 1'b1;
                        end else begin
                            go = 1'b1;
                            if (useful_reg) begin
                                cnt_tmp = cnt_reg + 1'b1;
                            end else if (!space) begin
                                useful_next = 1'b1;
                                cnt_tmp     = cnt_reg + column_next;
                            end else begin
                                // Leading white space: only shift the byte history
                                prev2_next = prev_reg;
                                prev_next  = s_char_in;
                                go         = 1'b0;
                            end
                        end
                    end
                end

                if (go) begin
                    cnt_next = cnt_tmp;
                    if (cnt_tmp > sexpr_pkg::CNT_LIMIT) begin
                        fail_hit  = 1'b1;
                        fail_code = sexpr_pkg::ERR_LONG_EXPR;
                    end else if (!instr_reg && (kind_reg == sexpr_pkg::K_DONE) && !space) begin
                        fail_hit  = 1'b1;
                        fail_code = (s_char_in == sexpr_pkg::CH_RPAREN) ?
                                    sexpr_pkg::ERR_EXTRA_RPAR : sexpr_pkg::ERR_TRAILING;
                    end else begin
                        case (s_char_in)
                            sexpr_pkg::CH_LPAREN: begin
                                if (!instr_reg && !lit) begin
                                    if (depth_reg >= sexpr_pkg::DEPTH_MAX) begin
                                        fail_hit  = 1'b1;
                                        fail_code = sexpr_pkg::ERR_TOO_DEEP;
                                    end else begin
                                        depth_next = depth_reg + 1'b1;
                                        kind_next  = sexpr_pkg::K_PAREN;
                                    end
                                end
                            end
                            sexpr_pkg::CH_RPAREN: begin
                                if (!instr_reg && !lit) begin
                                    if (depth_reg == '0) begin
                                        fail_hit  = 1'b1;
                                        fail_code = sexpr_pkg::ERR_LEADING_RPAR;
                                    end else begin
                                        depth_next = depth_reg - 1'b1;
                                        if (depth_reg == {{(sexpr_pkg::DEPTH_BITS-1){1'b0}}, 1'b1})
                                        begin
                                            kind_next = sexpr_pkg::K_DONE;
                                        end
                                    end
                                end
                            end
                            sexpr_pkg::CH_QUOTE: begin
                                // Quote after a backslash is escaped
                                if (prev_reg != sexpr_pkg::CH_BSLASH) begin
                                    if (!instr_reg) begin
                                        if (kind_reg == sexpr_pkg::K_ATOM) begin
                                            fail_hit  = 1'b1;
                                            fail_code = sexpr_pkg::ERR_STR_AFTER;
                                        end else begin
                                            instr_next = 1'b1;
                                            if (kind_reg != sexpr_pkg::K_PAREN) begin
                                                kind_next = sexpr_pkg::K_STRING;
                                            end
                                        end
                                    end else begin
                                        instr_next = 1'b0;
                                        if (kind_reg == sexpr_pkg::K_STRING) begin
                                            kind_next = sexpr_pkg::K_DONE;
                                        end
                                    end
                                end
                            end
                            default: begin
                                if (!instr_reg) begin
                                    if (space) begin
                                        if (kind_reg == sexpr_pkg::K_ATOM) begin
                                            kind_next = sexpr_pkg::K_DONE;
                                        end
                                    end else if (kind_reg != sexpr_pkg::K_PAREN) begin
                                        kind_next = sexpr_pkg::K_ATOM;
                                    end
                                end
                            end
                        endcase
                        if (!fail_hit) begin
                            prev2_next = prev_reg;
                            prev_next  = s_char_in;
                        end
                    end
                end

                // Error: drop the expression and skip the rest of the line
                if (fail_hit) begin
                    depth_next = '0;
                    instr_next = 1'b0;
                    kind_next  = sexpr_pkg::K_NONE;
                    cnt_next   = '0;
                    skip_next  = 1'b1;
                    res0       = '{sexpr_pkg::ST_ERR, fail_code, 1'b1};
                    n_res      = 2'd1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Queue pointers
    // ------------------------------------------------------------------------
    always_comb begin
        head_next = head_reg + sexpr_pkg::QPTR_W'(out_xfer);
        tail_next = tail_reg + sexpr_pkg::QPTR_W'(n_res);
        qcnt_next = qcnt_reg + sexpr_pkg::QCNT_W'(n_res)
                             - sexpr_pkg::QCNT_W'(out_xfer);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            depth_reg   <= '0;
            instr_reg   <= 1'b0;
            kind_reg    <= sexpr_pkg::K_NONE;
            prev_reg    <= '0;
            prev2_reg   <= '0;
            column_reg  <= '0;
            cnt_reg     <= '0;
            useful_reg  <= 1'b0;
            comment_reg <= 1'b0;
            skip_reg    <= 1'b0;
            head_reg    <= '0;
            tail_reg    <= '0;
            qcnt_reg    <= '0;
        end else begin
            depth_reg   <= depth_next;
            instr_reg   <= instr_next;
            kind_reg    <= kind_next;
            prev_reg    <= prev_next;
            prev2_reg   <= prev2_next;
            column_reg  <= column_next;
            cnt_reg     <= cnt_next;
            useful_reg  <= useful_next;
            comment_reg <= comment_next;
            skip_reg    <= skip_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            qcnt_reg    <= qcnt_next;
        end
    end

    // Queue payload: write up to two results at the tail
    always_ff @(posedge aclk) begin
        if (n_res != 2'd0) begin
            q_reg[tail_reg] <= res0;
        end
        if (n_res == 2'd2) begin
            q_reg[tail_reg + 1'b1] <= res1;
        end
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    `ASSERT_IMPL(a_q_bound, 1'b1, qcnt_reg <= sexpr_pkg::QCNT_W'(sexpr_pkg::QDEPTH),
                 "result queue overflow")
    `ASSERT_IMPL(a_end_last, m_valid && (m_status == sexpr_pkg::ST_END), m_last_result,
                 "END result without last flag")
    `ASSERT_IMPL(a_kind_zero, m_valid && (m_status != sexpr_pkg::ST_ERR),
                 m_error_kind == sexpr_pkg::ERR_NONE, "error kind set on non-error result")
    `ASSERT_NEXT(a_eoi_reset, in_xfer && s_end_of_input,
                 (depth_reg == '0) && !instr_reg && !skip_reg && (column_reg == '0),
                 "parse state not cleared after end of input")

endmodule

[tb/tb_sexpr_framer_unit.sv]
// ----------------------------------------------------------------------------
// tb_sexpr_framer_unit
// Self-checking bench for the S-expression framer. A directed text covers
// the short error kinds, character literals, escaped quotes, comments, blank
// lines, the depth limit and each end-of-input outcome. Random text
// follows: mostly well-formed expressions with random content, mixed with
// broken lines, raw byte noise and end-of-input markers. A bit-exact
// parser model predicts the results of every input transfer; the monitor
// compares each result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_sexpr_framer_unit;
    import sexpr_pkg::*;

    localparam int RESET_CYCLES   = 11;
    localparam int IDLE_PCT       = 36;     // idle chance per cycle, each side
    localparam int ITEM_TOTAL     = 1950;   // least number of input transfers in the run
    localparam int CALM_START     = 1200;   // transfer window with no idling
    localparam int CALM_END       = 1500;
    localparam int DRAIN_CYCLES   = 8;      // settle time after the last result
    localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer at all
    localparam int NEVER          = 32'h7fffffff;

    localparam logic [7:0] CH_VT = 8'd11;
    localparam logic [7:0] CH_FF = 8'd12;

    // One entry of the stimulus queue. A hold entry is no transfer: it
    // stalls the sender until every predicted result has been received.
    typedef struct {
        logic [7:0] ch;
        logic       eoi;
        bit         hold;
    } feed_item_t;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_in      = 8'd0;
    logic       s_end_of_input = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic [1:0] m_status;
    logic [3:0] m_error_kind;
    logic       m_last_result;

    feed_item_t feed_q[$];      // bytes waiting to be sent
    res_t       want_q[$];      // predicted results, oldest first

    int fed_total    = 0;       // transfers queued
    int sent_cnt     = 0;       // transfers accepted
    int bad_cnt      = 0;
    int stall_cycles = 0;
    int calm_lo      = NEVER;   // transfer window with no idling on either side
    int calm_hi      = NEVER;

    wire calm = (sent_cnt >= calm_lo) && (sent_cnt < calm_hi);

    // Parser model state
    logic [DEPTH_BITS-1:0] nest      = '0;
    logic                  in_str    = 1'b0;
    kind_t                 kind      = K_NONE;
    logic [7:0]            prev1     = '0;
    logic [7:0]            prev2     = '0;
    logic [COL_W-1:0]      col       = '0;
    logic [CNT_W-1:0]      span      = '0;
    logic                  useful    = 1'b0;
    logic                  in_cmt    = 1'b0;
    logic                  skip_rest = 1'b0;

    sexpr_framer_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_in      (s_char_in),
        .s_end_of_input (s_end_of_input),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_status       (m_status),
        .m_error_kind   (m_error_kind),
        .m_last_result  (m_last_result)
    );

    always #2 aclk = ~aclk;

    // ------------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------------
    function automatic void note(status_t st, err_t ek);
        want_q.push_back('{status: st, error_kind: ek, last: 1'b0});
    endfunction

    function automatic void drop_expr();
        nest   = '0;
        in_str = 1'b0;
        kind   = K_NONE;
        span   = '0;
    endfunction

    function automatic void drop_line();
        col       = '0;
        prev1     = '0;
        prev2     = '0;
        useful    = 1'b0;
        in_cmt    = 1'b0;
        skip_rest = 1'b0;
    endfunction

    // Report an error, forget the expression and ignore the rest of the line.
    function automatic void abort_expr(err_t ek);
        drop_expr();
        skip_rest = 1'b1;
        note(ST_ERR, ek);
    endfunction

    function automatic void frame_byte(logic [7:0] ch, logic eoi);
        logic blank;
        logic lit;
        if (eoi) begin
            if (!skip_rest) begin
                if (in_str)
                    note(ST_ERR, ERR_OPEN_STRING);
                else if (nest != '0)
                    note(ST_ERR, ERR_MISSING_RPAR);
                else if (useful)
                    note(ST_OK, ERR_NONE);
            end
            note(ST_END, ERR_NONE);
            drop_expr();
            drop_line();
            return;
        end
        if (ch == CH_NL) begin
            if (!skip_rest && useful) begin
                if (in_str) begin
                    drop_expr();
                    note(ST_ERR, ERR_OPEN_STRING);
                end else if (nest == '0) begin
                    drop_expr();
                    note(ST_OK, ERR_NONE);
                end else begin
                    // a line break inside an open list counts as one byte
                    span = span + 1'b1;
                    if (span > MAX_CHARS - 1) begin
                        drop_expr();
                        note(ST_ERR, ERR_LONG_EXPR);
                    end
                end
            end
            drop_line();
            return;
        end
        if (skip_rest)
            return;
        if (col >= MAX_CHARS - 2) begin
            abort_expr(ERR_LONG_LINE);
            return;
        end
        col = col + 1'b1;
        if (in_cmt)
            return;
        blank = (ch == CH_SPACE) || (ch >= CH_TAB && ch <= CH_CR);
        if (!in_str && ch == CH_SEMI) begin
            in_cmt = 1'b1;
            return;
        end
        if (useful) begin
            span = span + 1'b1;
        end else if (!blank) begin
            // first useful byte: count the leading white space too
            useful = 1'b1;
            span   = span + col;
        end else begin
            prev2 = prev1;
            prev1 = ch;
            return;
        end
        if (span > MAX_CHARS - 1) begin
            abort_expr(ERR_LONG_EXPR);
            return;
        end
        if (!in_str && kind == K_DONE && !blank) begin
            abort_expr(ch == CH_RPAREN ? ERR_EXTRA_RPAR : ERR_TRAILING);
            return;
        end
        lit = (prev1 == CH_BSLASH) && (prev2 == CH_HASH);
        if (ch == CH_LPAREN) begin
            if (!in_str && !lit) begin
                if (nest == DEPTH_MAX) begin
                    abort_expr(ERR_TOO_DEEP);
                    return;
                end
                nest = nest + 1'b1;
                kind = K_PAREN;
            end
        end else if (ch == CH_RPAREN) begin
            if (!in_str && !lit) begin
                if (nest == '0) begin
                    abort_expr(ERR_LEADING_RPAR);
                    return;
                end
                nest = nest - 1'b1;
                if (nest == '0)
                    kind = K_DONE;
            end
        end else if (ch == CH_QUOTE) begin
            if (prev1 != CH_BSLASH) begin
                if (!in_str) begin
                    if (kind == K_ATOM) begin
                        abort_expr(ERR_STR_AFTER);
                        return;
                    end
                    in_str = 1'b1;
                    if (kind != K_PAREN)
                        kind = K_STRING;
                end else begin
                    in_str = 1'b0;
                    if (kind == K_STRING)
                        kind = K_DONE;
                end
            end
        end else if (!in_str) begin
            if (blank) begin
                if (kind == K_ATOM)
                    kind = K_DONE;
            end else if (kind != K_PAREN) begin
                kind = K_ATOM;
            end
        end
        prev2 = prev1;
        prev1 = ch;
    endfunction

    // ------------------------------------------------------------------------
    // Text generation
    // ------------------------------------------------------------------------
    task automatic put(input logic [7:0] ch);
        feed_q.push_back('{ch: ch, eoi: 1'b0, hold: 1'b0});
        fed_total++;
    endtask

    task automatic put_text(input string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endtask

    // char_in is random on an end-of-input transfer; the block ignores it
    task automatic put_eoi();
        feed_q.push_back('{ch: 8'($urandom), eoi: 1'b1, hold: 1'b0});
        fed_total++;
    endtask

    task automatic put_hold();
        feed_q.push_back('{ch: 8'h00, eoi: 1'b0, hold: 1'b1});
    endtask

    task automatic put_pad(input int lo);
        repeat ($urandom_range(3, lo)) begin
            case ($urandom_range(7))
                0: put(CH_TAB);
                1: put(CH_CR);
                2: put(CH_VT);
                3: put(CH_FF);
                default: put(CH_SPACE);
            endcase
        end
    endtask

    task automatic put_atom();
        string pool;
        pool = "abcdefghijklmnopqrstuvwxyz0123456789+-*/<=>!?_.:";
        repeat ($urandom_range(6, 1)) begin
            case ($urandom_range(15))
                0: put_text("#\\(");
                1: put_text("#\\)");
                2: put(8'($urandom_range(255, 127)));
                3: put(8'($urandom_range(8, 0)));
                4: put(8'($urandom_range(31, 14)));
                default: put(pool[$urandom_range(pool.len() - 1)]);
            endcase
        end
    endtask

    task automatic put_str();
        string pool;
        pool = "abcXYZ 019();#";
        put(CH_QUOTE);
        repeat ($urandom_range(6, 0)) begin
            case ($urandom_range(9))
                0: put_text("\\\"");
                1: put(8'($urandom_range(255, 128)));
                default: put(pool[$urandom_range(pool.len() - 1)]);
            endcase
        end
        put(CH_QUOTE);
    endtask

    // Comment from ';' up to, not including, the newline.
    task automatic put_note();
        put(CH_SEMI);
        repeat ($urandom_range(8, 0))
            put(8'($urandom_range(255, 11)));
    endtask

    // Balanced list built without recursion; may span several lines.
    task automatic put_list();
        int opened;
        int budget;
        put(CH_LPAREN);
        opened = 1;
        budget = $urandom_range(10, 1);
        while (opened > 0) begin
            if (budget == 0) begin
                put(CH_RPAREN);
                opened--;
            end else begin
                budget--;
                case ($urandom_range(9))
                    0, 1: begin
                        if (opened < 6) begin
                            put(CH_LPAREN);
                            opened++;
                        end
                    end
                    2, 3: begin
                        put_atom();
                        put_pad(1);
                    end
                    4, 5: begin
                        put_str();
                        put_pad(0);
                    end
                    6, 7: begin
                        put(CH_RPAREN);
                        opened--;
                        put_pad(0);
                    end
                    default: begin
                        if ($urandom_range(1))
                            put_note();
                        put(CH_NL);
                        put_pad(0);
                    end
                endcase
            end
        end
    endtask

    task automatic put_expr();
        case ($urandom_range(9))
            0, 1, 2: put_atom();
            3, 4:    put_str();
            default: put_list();
        endcase
    endtask

    // Rest of a line after an error: ignored by the block.
    task automatic put_tail();
        if ($urandom_range(1)) begin
            put_pad(0);
            put_atom();
        end
        put(CH_NL);
    endtask

    // ------------------------------------------------------------------------
    // Driver: when the input slot is free, present the next queued item or stay idle.
    // Predict the results of each transfer at the edge that accepts it.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : drive
        feed_item_t nxt;
        res_t       tail;
        int         prior_cnt;
        logic       go;
        if (!aresetn) begin
            s_valid        <= 1'b0;
            s_char_in      <= 8'd0;
            s_end_of_input <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                prior_cnt = want_q.size();
                frame_byte(s_char_in, s_end_of_input);
                // flag the final result of this transfer
                if (want_q.size() > prior_cnt) begin
                    tail      = want_q.pop_back();
                    tail.last = 1'b1;
                    want_q.push_back(tail);
                end
                sent_cnt++;
            end
            if (!s_valid || s_ready) begin
                // release a hold once every predicted result has arrived
                if (feed_q.size() > 0 && feed_q[0].hold && want_q.size() == 0)
                    void'(feed_q.pop_front());
                go = feed_q.size() > 0 && !feed_q[0].hold &&
                     (calm || $urandom_range(99) >= IDLE_PCT);
                if (go) begin
                    nxt = feed_q.pop_front();
                    s_char_in      <= nxt.ch;
                    s_end_of_input <= nxt.eoi;
                end
                s_valid <= go;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: check each result transfer against the oldest prediction and
    // stall the result channel at random.
    // ------------------------------------------------------------------------
    always @(posedge aclk) begin : watch
        res_t due;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (want_q.size() == 0) begin
                    $error("unexpected result: status %0d error_kind %0d",
                           m_status, m_error_kind);
                    bad_cnt++;
                end else begin
                    due = want_q.pop_front();
                    if (m_status !== due.status) begin
                        $error("status: expected %0d, actual %0d", due.status, m_status);
                        bad_cnt++;
                    end
                    if (m_error_kind !== due.error_kind) begin
                        $error("error_kind: expected %0d, actual %0d",
                               due.error_kind, m_error_kind);
                        bad_cnt++;
                    end
                    if (m_last_result !== due.last) begin
                        $error("last_result: expected %0d, actual %0d",
                               due.last, m_last_result);
                        bad_cnt++;
                    end
                end
            end
            m_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Watchdog: end the run if neither channel moves for too long.
    always @(posedge aclk) begin : watchdog
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin : stimulus
        int roll;

        // Directed text: the short error kinds and the special bytes
        put_text("a\n");                // plain atom
        put_text(")\n");                // ')' with nothing open
        put_text("(x)y\n");             // trailing atom after the expression
        put_text("()) ;c\n");           // surplus ')'
        put_text("ab\"c\"\n");          // string right after an atom
        put_text("\"s\n");              // string still open at the newline
        put_text(" #\\( \t;(\n");       // character literal, then a comment
        put_text("\"a\\\"b\"\n");       // escaped quote inside a string
        put(8'h00);                     // NUL and 0xFF are atom bytes
        put(8'hff);
        put(CH_NL);
        put_text("  \n;x\n");           // blank and comment-only lines
        put_text("(q\n");               // list left open at end of input
        put_eoi();
        put_text("\"o");                // string left open at end of input
        put_eoi();
        put_text("z");                  // pending expression at end of input
        put_eoi();
        put_text(")x");                 // end of input while skipping a line
        put_eoi();
        put_eoi();                      // nothing pending at all

        // Deepest legal nesting, then one level too deep
        repeat (int'(DEPTH_MAX)) put(CH_LPAREN);
        repeat (int'(DEPTH_MAX)) put(CH_RPAREN);
        put(CH_NL);
        repeat (int'(DEPTH_MAX) + 1) put(CH_LPAREN);
        put_text(")\n");

        // Let the block drain completely before the random text
        put_hold();

        // Random text, mostly well-formed
        while (fed_total < ITEM_TOTAL) begin
            if (fed_total >= CALM_START && calm_lo == NEVER)
                calm_lo = fed_total;
            if (fed_total >= CALM_END && calm_hi == NEVER)
                calm_hi = fed_total;
            roll = $urandom_range(99);
            if (roll < 55) begin
                put_pad(0);
                put_expr();
                put_pad(0);
                if ($urandom_range(3) == 0)
                    put_note();
                put(CH_NL);
            end else if (roll < 62) begin
                put_pad(0);
                if ($urandom_range(1))
                    put_note();
                put(CH_NL);
            end else if (roll < 78) begin
                case ($urandom_range(5))
                    0: begin                        // trailing atom
                        put_expr();
                        put_pad(1);
                        put_atom();
                        put_tail();
                    end
                    1: begin                        // surplus ')'
                        put_expr();
                        put(CH_RPAREN);
                        put_tail();
                    end
                    2: begin                        // string after atom
                        put_atom();
                        put_str();
                        put_tail();
                    end
                    3: begin                        // unterminated string
                        put(CH_QUOTE);
                        put_atom();
                        put(CH_NL);
                    end
                    4: begin                        // leading ')'
                        put(CH_RPAREN);
                        put_tail();
                    end
                    default: begin                  // leave a list open
                        put(CH_LPAREN);
                        put_atom();
                        put(CH_NL);
                    end
                endcase
            end else if (roll < 87) begin
                // raw byte noise, any value
                repeat ($urandom_range(10, 1))
                    put(8'($urandom));
                if ($urandom_range(9) < 7)
                    put(CH_NL);
            end else if (roll < 98) begin
                case ($urandom_range(3))
                    0: put_expr();
                    1: begin
                        put(CH_LPAREN);
                        put_atom();
                    end
                    2: begin
                        put(CH_QUOTE);
                        put_atom();
                    end
                    default: ;
                endcase
                put_eoi();
            end else begin
                put_hold();
            end
        end
        put_eoi();

        // Reset once, then let the driver and monitor run
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        do @(negedge aclk);
        while (sent_cnt < fed_total || want_q.size() != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (bad_cnt == 0 && want_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
